// ----- sv/u16u8_pkg.sv -----
// Shared constants and types for the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps
package u16u8_pkg;

	localparam int UnitWidth   = 16;
	localparam int ByteWidth   = 8;
	localparam int LeadBits    = 10;
	localparam int MaxBytes    = 4;
	localparam int CountWidth  = $clog2(MaxBytes + 1);

	localparam logic [ByteWidth-1:0] QMark = 8'h3F;

	typedef logic [ByteWidth-1:0]  byte_t;
	typedef logic [CountWidth-1:0] count_t;

	// Result of encoding one code unit against the held surrogate state.
	typedef struct packed {
		logic [MaxBytes-1:0][ByteWidth-1:0] bytes;
		count_t                             count;
		logic                               hold;
		logic [LeadBits-1:0]                held_bits;
	} enc_t;

endpackage

// ----- sv/u16u8_intf.sv -----
// Valid/ready stream interfaces for code units and UTF-8 bytes.
`timescale 1ns / 1ps
interface u16u8_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        end_of_string;

	modport source(output valid, code_unit, end_of_string, input ready);
	modport sink(input valid, code_unit, end_of_string, output ready);
endinterface

interface u16u8_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source(output valid, out_byte, last_of_run, input ready);
	modport sink(input valid, out_byte, last_of_run, output ready);
endinterface

// ----- sv/utf16_to_utf8_encoder_core.sv -----
// Top level of the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps
// Accepts one UTF-16 code unit per request and emits its UTF-8 bytes one per
// cycle on the byte channel while ready is high, with last_of_run marking the
// final byte of each unit. A unit yields 0 to 4 bytes; they are drained from
// a four-byte shift register, and the next unit is accepted in the cycle the
// last byte leaves. A lead surrogate is held inside and gives no bytes until
// the following unit arrives; malformed surrogates give '?'.
module utf16_to_utf8_encoder_core (
	input  logic             clk,
	input  logic             arst_n,
	u16u8_unit_if.sink       units,
	u16u8_byte_if.source     utf8
);
	import u16u8_pkg::*;

	logic                               pending_q;
	logic [LeadBits-1:0]                held_q;
	logic [MaxBytes-1:0][ByteWidth-1:0] buf_q;
	count_t                             cnt_q;
	enc_t                               enc;
	logic                               in_fire;
	logic                               out_fire;

	u16u8_enc u_enc (
		.code_unit      (units.code_unit),
		.end_of_string  (units.end_of_string),
		.lead_pending   (pending_q),
		.held_lead_bits (held_q),
		.enc            (enc)
	);

	assign out_fire = utf8.valid && utf8.ready;
	assign in_fire  = units.valid && units.ready;

	// A new unit may load as soon as the last buffered byte is leaving.
	assign units.ready = (cnt_q == '0) || ((cnt_q == count_t'(1)) && utf8.ready);

	assign utf8.valid       = (cnt_q != '0);
	assign utf8.out_byte    = buf_q[0];
	assign utf8.last_of_run = (cnt_q == count_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			held_q    <= '0;
			cnt_q     <= '0;
		end else if (in_fire) begin
			pending_q <= enc.hold;
			held_q    <= enc.held_bits;
			cnt_q     <= enc.count;
		end else if (out_fire) begin
			cnt_q <= cnt_q - count_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			buf_q <= enc.bytes;
		end else if (out_fire) begin
			buf_q <= {8'h00, buf_q[MaxBytes-1:1]};
		end
	end

endmodule

// ----- sv/u16u8_enc.sv -----
// Combinational encoder: one code unit plus held surrogate state to up to four bytes.
`timescale 1ns / 1ps
module u16u8_enc (
	input  logic [u16u8_pkg::UnitWidth-1:0] code_unit,
	input  logic                 end_of_string,
	input  logic                 lead_pending,
	input  logic [9:0]           held_lead_bits,
	output u16u8_pkg::enc_t      enc
);
	import u16u8_pkg::*;

	logic                        is_sur;
	logic                        is_lead;
	logic                        is_trail;
	logic [20:0]                 cp;
	logic [2:0][ByteWidth-1:0]   nb;
	count_t                      nn;
	logic                        n_hold;

	assign is_sur   = (code_unit[15:11] == 5'b11011);
	assign is_lead  = is_sur && !code_unit[10];
	assign is_trail = is_sur && code_unit[10];
	assign cp       = 21'h10000 + {1'b0, held_lead_bits, code_unit[9:0]};

	// Plain encoding of the unit as if no lead were held.
	always_comb begin
		nb     = '0;
		nn     = '0;
		n_hold = 1'b0;
		priority if (code_unit[15:7] == '0) begin
			nb[0] = code_unit[7:0];
			nn    = count_t'(1);
		end else if (code_unit[15:11] == '0) begin
			nb[0] = {3'b110, code_unit[10:6]};
			nb[1] = {2'b10, code_unit[5:0]};
			nn    = count_t'(2);
		end else if (is_sur) begin
			if (is_lead && !end_of_string) begin
				n_hold = 1'b1;
			end else begin
				nb[0] = QMark;
				nn    = count_t'(1);
			end
		end else begin
			nb[0] = {4'hE, code_unit[15:12]};
			nb[1] = {2'b10, code_unit[11:6]};
			nb[2] = {2'b10, code_unit[5:0]};
			nn    = count_t'(3);
		end
	end

	always_comb begin
		enc.held_bits = '0;
		if (lead_pending && is_trail) begin
			enc.bytes[0] = {5'b11110, cp[20:18]};
			enc.bytes[1] = {2'b10, cp[17:12]};
			enc.bytes[2] = {2'b10, cp[11:6]};
			enc.bytes[3] = {2'b10, cp[5:0]};
			enc.count    = count_t'(4);
			enc.hold     = 1'b0;
		end else if (lead_pending) begin
			// The held lead is malformed: a question mark comes first.
			enc.bytes = {nb, QMark};
			enc.count = nn + count_t'(1);
			enc.hold  = n_hold;
		end else begin
			enc.bytes = {8'h00, nb};
			enc.count = nn;
			enc.hold  = n_hold;
		end
		if (enc.hold) begin
			enc.held_bits = code_unit[9:0];
		end
	end

endmodule

// ----- test/tb_utf16_to_utf8_encoder_core.sv -----
// Self-checking testbench for the UTF-16 to UTF-8 encoder core.
`timescale 1ns / 1ps
import u16u8_pkg::*;

typedef struct {
	byte_t value;
	logic  last;
} utf8_byte_t;

// Tracks the surrogate state of the string and keeps the UTF-8 bytes that are
// still owed by the encoder, oldest first.
class utf8_scoreboard;
	logic                lead_held;
	logic [LeadBits-1:0] held_bits;
	byte_t               run_bytes[$];
	utf8_byte_t          owed_bytes[$];

	function new();
		lead_held = 1'b0;
		held_bits = '0;
	endfunction

	// Encodes a unit while no lead surrogate is held; a lead may become held.
	function void encode_plain(logic [15:0] cu, logic eos);
		if (cu < 16'h0080) begin
			run_bytes.push_back(cu[7:0]);
		end else if (cu < 16'h0800) begin
			run_bytes.push_back({3'b110, cu[10:6]});
			run_bytes.push_back({2'b10, cu[5:0]});
		end else if (cu[15:11] == 5'b11011) begin
			if (!cu[10] && !eos) begin
				lead_held = 1'b1;
				held_bits = cu[9:0];
			end else begin
				run_bytes.push_back(QMark);
			end
		end else begin
			run_bytes.push_back({4'b1110, cu[15:12]});
			run_bytes.push_back({2'b10, cu[11:6]});
			run_bytes.push_back({2'b10, cu[5:0]});
		end
	endfunction

	function void note_unit(logic [15:0] cu, logic eos);
		logic [20:0] cp;
		utf8_byte_t  e;
		run_bytes.delete();
		if (lead_held) begin
			lead_held = 1'b0;
			if (cu[15:10] == 6'b110111) begin
				cp = 21'h10000 + {1'b0, held_bits, cu[9:0]};
				held_bits = '0;
				run_bytes.push_back({5'b11110, cp[20:18]});
				run_bytes.push_back({2'b10, cp[17:12]});
				run_bytes.push_back({2'b10, cp[11:6]});
				run_bytes.push_back({2'b10, cp[5:0]});
			end else begin
				held_bits = '0;
				run_bytes.push_back(QMark);
				encode_plain(cu, eos);
			end
		end else begin
			encode_plain(cu, eos);
		end
		foreach (run_bytes[i]) begin
			e.value = run_bytes[i];
			e.last  = (i == run_bytes.size() - 1);
			owed_bytes.push_back(e);
		end
	endfunction

	function int outstanding();
		return owed_bytes.size();
	endfunction

	// Returns an empty string when the byte matches the oldest owed byte.
	function string check_byte(byte_t got, logic got_last);
		utf8_byte_t want;
		string      why;
		why = "";
		if (owed_bytes.size() == 0)
			return $sformatf("byte %02h arrived with nothing owed", got);
		want = owed_bytes.pop_front();
		if (got !== want.value)
			why = $sformatf("out_byte %02h, expected %02h", got, want.value);
		if (got_last !== want.last)
			why = {why, (why == "") ? "" : "; ",
				$sformatf("last_of_run %0b, expected %0b", got_last, want.last)};
		return why;
	endfunction
endclass

module tb_utf16_to_utf8_encoder_core;
	logic clk;
	logic arst_n;
	int   errors = 0;
	bit   idle_on = 1'b1;
	bit   hold_request = 1'b0;

	utf8_scoreboard sb = new();

	u16u8_unit_if units();
	u16u8_byte_if utf8();

	utf16_to_utf8_encoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.units  (units),
		.utf8   (utf8)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report(input string why);
		$display("MISMATCH at %0t ns: %s", $time, why);
		errors++;
	endtask

	always @(posedge clk) begin : monitor
		string why;
		if (arst_n) begin
			if (units.valid && units.ready)
				sb.note_unit(units.code_unit, units.end_of_string);
			if (utf8.valid && utf8.ready) begin
				why = sb.check_byte(utf8.out_byte, utf8.last_of_run);
				if (why != "")
					report(why);
			end
		end
	end

	// Byte receiver: random stall bursts, plus one long hold-off on request.
	initial begin : byte_sink
		int stall_left;
		stall_left = 0;
		utf8.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = 80;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 14);
			end
			if (stall_left > 0) begin
				utf8.ready <= 1'b0;
				stall_left--;
			end else begin
				utf8.ready <= 1'b1;
			end
		end
	end

	// Offers one code unit and returns once the request is taken.
	task automatic send_unit(input logic [15:0] cu, input logic eos);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 14);
		@(negedge clk);
		if (gap > 0) begin
			units.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		units.valid         <= 1'b1;
		units.code_unit     <= cu;
		units.end_of_string <= eos;
		do @(posedge clk); while (!(units.valid && units.ready));
	endtask

	// Mostly well-formed text with surrogate pairs, some broken surrogates
	// and fully random units mixed in.
	task automatic send_text(input int count);
		int          sent;
		int          pick;
		logic        eos;
		logic [15:0] cu;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 9);
			eos  = ($urandom_range(0, 7) == 0);
			case (pick)
				0, 1: begin
					cu = 16'($urandom_range(16'h0000, 16'h007F));
					send_unit(cu, eos);
				end
				2: begin
					cu = 16'($urandom_range(16'h0080, 16'h07FF));
					send_unit(cu, eos);
				end
				3: begin
					// Skip the surrogate block to land on a three-byte unit.
					cu = 16'($urandom_range(16'h0800, 16'hF7FF));
					if (cu >= 16'hD800)
						cu = cu + 16'h0800;
					send_unit(cu, eos);
				end
				4, 5, 6: begin
					cu = 16'($urandom_range(16'hD800, 16'hDBFF));
					send_unit(cu, 1'b0);
					cu = 16'($urandom_range(16'hDC00, 16'hDFFF));
					send_unit(cu, eos);
					sent++;
				end
				7: begin
					cu = 16'($urandom_range(16'hD800, 16'hDBFF));
					send_unit(cu, eos);
				end
				8: begin
					cu = 16'($urandom_range(16'hDC00, 16'hDFFF));
					send_unit(cu, eos);
				end
				default: begin
					cu = 16'($urandom_range(0, 16'hFFFF));
					send_unit(cu, eos);
				end
			endcase
			sent++;
		end
	endtask

	initial begin : stimulus
		arst_n              = 1'b0;
		units.valid         = 1'b0;
		units.code_unit     = '0;
		units.end_of_string = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Boundaries of each encoding length.
		send_unit(16'h0000, 1'b1);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hD7FF, 1'b0);
		send_unit(16'hE000, 1'b0);
		send_unit(16'hFFFF, 1'b1);
		// Lowest and highest surrogate pairs; the second pair ends the string.
		send_unit(16'hD800, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hDBFF, 1'b0);
		send_unit(16'hDFFF, 1'b1);
		// Held leads followed by non-trails (ASCII, other leads, U+FFFF), and one valid pair.
		send_unit(16'hD800, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hDA00, 1'b0);
		send_unit(16'hDB00, 1'b0);
		send_unit(16'hDC80, 1'b0);
		send_unit(16'hD900, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		send_unit(16'hD800, 1'b0);
		send_unit(16'hDBFF, 1'b1);
		// Lone trails and a lead that ends the string.
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hDFFF, 1'b1);
		send_unit(16'hDBFF, 1'b1);

		send_text(100);
		// The receiver stalls for a long stretch while units keep coming.
		hold_request = 1'b1;
		send_text(60);
		idle_on = 1'b0;
		send_text(60);

		@(negedge clk);
		units.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule

// ----- utf16_to_utf8_encoder_core.f -----
sv/u16u8_pkg.sv
sv/u16u8_intf.sv
sv/u16u8_enc.sv
sv/utf16_to_utf8_encoder_core.sv
test/tb_utf16_to_utf8_encoder_core.sv
